// ===== sv/otcp_pkg.sv =====
package otcp_pkg;

    localparam int LENGTH_WIDTH_DEFAULT = 32;
    localparam int PLEN_WIDTH = 31;
    localparam int WORD_WIDTH = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int NUM_KEYS = 5;

    localparam logic [15:0] MAX_VALUE_LENGTH_RESET = 16'd255;
    localparam logic [30:0] MIN_PACKET_LENGTH = 31'd16;
    localparam logic [30:0] LENGTH_WORD_BYTES = 31'd4;

    localparam logic REG_MAX_VALUE_LENGTH = 1'b0;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    localparam logic [2:0] TAG_VENDOR = 3'd0;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_MAGIC  = 4'd1,
        PH_VLEN   = 4'd2,
        PH_VENDOR = 4'd3,
        PH_COUNT  = 4'd4,
        PH_FLEN   = 4'd5,
        PH_FBODY  = 4'd6
    } phase_t;

    localparam logic [7:0] MAGIC_TEXT [0:7] = '{"O", "p", "u", "s", "T", "a", "g", "s"};

    localparam logic [7:0] KEY_TEXT [0:4][0:7] = '{
        '{"t", "i", "t", "l", "e", "=", 8'h00, 8'h00},
        '{"a", "r", "t", "i", "s", "t", "=", 8'h00},
        '{"a", "l", "b", "u", "m", "=", 8'h00, 8'h00},
        '{"d", "a", "t", "e", "=", 8'h00, 8'h00, 8'h00},
        '{"t", "r", "a", "c", "k", "=", 8'h00, 8'h00}
    };

    localparam logic [3:0] KEY_LEN [0:4] = '{4'd6, 4'd7, 4'd6, 4'd5, 4'd6};

endpackage

// ===== sv/opus_tags_comment_parser_top.sv =====
// Channel  Direction  Handshake          Payload
// s_       in         s_tvalid/s_tready  tdata: data_byte, packet_length; tuser: start_req;
//                                        tlast: last
// m_       out        m_tvalid/m_tready  tdata: tag, value_byte, status; tuser: value_valid;
//                                        tlast: status_valid
// apb      in         psel/penable       max_value_length at byte address 0
//
// One byte is taken per cycle while m_ does not stall; a byte taken goes to the input
// register and from there, in a single pass, to the result register.
// Bytes that give no result leave nothing on m_.
// Reset is synchronous on aresetn low and returns the parser to idle.
// A stall on m_ holds the waiting result; the input register can still take one byte,
// and s_tready is low while both are held.
module opus_tags_comment_parser_top #(
    parameter int LENGTH_WIDTH = otcp_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] data_byte, [38:8] packet_length, [39] zero
    input  logic [39:0] s_tdata,
    // [0] start_req
    input  logic        s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] tag, [10:3] value_byte, [11] status, [15:12] zero
    output logic [15:0] m_tdata,
    // [0] value_valid
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FW = LENGTH_WIDTH - 1;
    localparam int PW = otcp_pkg::PLEN_WIDTH;
    localparam int WW = otcp_pkg::WORD_WIDTH;
    localparam int CW = otcp_pkg::COUNT_WIDTH;
    localparam int NK = otcp_pkg::NUM_KEYS;

    logic [CW-1:0] max_len_reg;

    logic          in_valid_reg;
    logic          in_start_reg;
    logic [7:0]    in_byte_reg;
    logic [PW-1:0] in_plen_reg;
    logic          in_last_reg;

    logic          out_valid_reg;
    logic          out_val_reg;
    logic [2:0]    out_tag_reg;
    logic [7:0]    out_byte_reg;
    logic          out_stv_reg;
    logic          out_st_reg;

    otcp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]    mpos_reg, mpos_next;
    logic [1:0]    wbi_reg, wbi_next;
    logic [WW-1:0] word_reg, word_next;
    logic [PW-1:0] budget_reg, budget_next;
    logic [FW-1:0] fields_reg, fields_next;
    logic [FW-1:0] fbl_reg, fbl_next;
    logic [NK-1:0] cand_reg, cand_next;
    logic [2:0]    kpos_reg, kpos_next;
    logic [2:0]    atag_reg, atag_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          zero_reg, zero_next;

    logic          res_val;
    logic [2:0]    res_tag;
    logic [7:0]    res_byte;
    logic          res_stv;
    logic          res_st;

    logic s_accept;
    logic out_free;
    logic step;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == otcp_pkg::REG_MAX_VALUE_LENGTH) ?
                       {{(32-CW){1'b0}}, max_len_reg} : 32'd0;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign step     = in_valid_reg && out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_val_reg;
    assign m_tlast  = out_stv_reg;
    assign m_tdata  = {4'd0, out_st_reg, out_byte_reg, out_tag_reg};

    always_comb begin
        logic [WW-1:0] w;
        logic          w_done;
        logic          w_big;
        logic [7:0]    lc;
        logic [PW-1:0] b_sub;
        logic          emit_en;
        logic [2:0]    emit_tag;
        logic          do_next;
        logic          hit;
        logic          skip;
        otcp_pkg::phase_t cur;

        phase_next  = phase_reg;
        mpos_next   = mpos_reg;
        wbi_next    = wbi_reg;
        word_next   = word_reg;
        budget_next = budget_reg;
        fields_next = fields_reg;
        fbl_next    = fbl_reg;
        cand_next   = cand_reg;
        kpos_next   = kpos_reg;
        atag_next   = atag_reg;
        cnt_next    = cnt_reg;
        zero_next   = zero_reg;

        res_val  = 1'b0;
        res_tag  = otcp_pkg::TAG_VENDOR;
        res_byte = 8'd0;
        res_stv  = 1'b0;
        res_st   = otcp_pkg::STATUS_OK;

        w        = '0;
        w_done   = 1'b0;
        w_big    = 1'b0;
        lc       = 8'd0;
        b_sub    = '0;
        emit_en  = 1'b0;
        emit_tag = otcp_pkg::TAG_VENDOR;
        do_next  = 1'b0;
        hit      = 1'b0;
        skip     = 1'b0;
        cur      = otcp_pkg::PH_IDLE;

        if (step) begin
            if (in_start_reg) begin
                phase_next  = otcp_pkg::PH_MAGIC;
                mpos_next   = 3'd0;
                wbi_next    = 2'd0;
                word_next   = '0;
                budget_next = in_plen_reg;
                fields_next = '0;
                fbl_next    = '0;
                cand_next   = '1;
                kpos_next   = 3'd0;
                atag_next   = otcp_pkg::TAG_VENDOR;
                cnt_next    = '0;
                zero_next   = 1'b0;
                if (in_plen_reg < otcp_pkg::MIN_PACKET_LENGTH) begin
                    res_stv    = 1'b1;
                    res_st     = otcp_pkg::STATUS_BAD;
                    phase_next = otcp_pkg::PH_IDLE;
                    skip       = 1'b1;
                end
            end

            if (!skip) begin
                w      = word_next | ({24'd0, in_byte_reg} << {wbi_next, 3'b000});
                w_done = (wbi_next == 2'd3);
                w_big  = (w[WW-1:FW] != '0);
                lc     = ((in_byte_reg >= "A") && (in_byte_reg <= "Z")) ?
                         in_byte_reg + 8'd32 : in_byte_reg;
                cur    = phase_next;

                unique case (cur)
                    otcp_pkg::PH_MAGIC: begin
                        if (in_byte_reg != otcp_pkg::MAGIC_TEXT[mpos_next]) begin
                            res_stv    = 1'b1;
                            res_st     = otcp_pkg::STATUS_BAD;
                            phase_next = otcp_pkg::PH_IDLE;
                        end else if (mpos_next == 3'd7) begin
                            mpos_next  = 3'd0;
                            word_next  = '0;
                            wbi_next   = 2'd0;
                            phase_next = otcp_pkg::PH_VLEN;
                        end else begin
                            mpos_next = mpos_next + 3'd1;
                        end
                    end
                    otcp_pkg::PH_VLEN: begin
                        word_next = w;
                        wbi_next  = wbi_next + 2'd1;
                        if (w_done) begin
                            b_sub = budget_next - otcp_pkg::MIN_PACKET_LENGTH;
                            if (w_big || (w > {1'b0, b_sub})) begin
                                res_stv    = 1'b1;
                                res_st     = otcp_pkg::STATUS_BAD;
                                phase_next = otcp_pkg::PH_IDLE;
                            end else begin
                                budget_next = b_sub - w[PW-1:0];
                                fbl_next    = w[FW-1:0];
                                cnt_next    = '0;
                                zero_next   = 1'b0;
                                if (w == '0) begin
                                    word_next  = '0;
                                    wbi_next   = 2'd0;
                                    phase_next = otcp_pkg::PH_COUNT;
                                end else begin
                                    phase_next = otcp_pkg::PH_VENDOR;
                                end
                            end
                        end
                    end
                    otcp_pkg::PH_VENDOR: begin
                        emit_en  = 1'b1;
                        emit_tag = otcp_pkg::TAG_VENDOR;
                        fbl_next = fbl_next - 1'b1;
                        if (fbl_next == '0) begin
                            word_next  = '0;
                            wbi_next   = 2'd0;
                            phase_next = otcp_pkg::PH_COUNT;
                        end
                    end
                    otcp_pkg::PH_COUNT: begin
                        word_next = w;
                        wbi_next  = wbi_next + 2'd1;
                        if (w_done) begin
                            if (w_big || (w > {3'd0, budget_next[PW-1:2]})) begin
                                res_stv    = 1'b1;
                                res_st     = otcp_pkg::STATUS_BAD;
                                phase_next = otcp_pkg::PH_IDLE;
                            end else begin
                                fields_next = w[FW-1:0];
                                do_next     = 1'b1;
                            end
                        end
                    end
                    otcp_pkg::PH_FLEN: begin
                        word_next = w;
                        wbi_next  = wbi_next + 2'd1;
                        if (w_done) begin
                            b_sub       = budget_next - otcp_pkg::LENGTH_WORD_BYTES;
                            budget_next = b_sub;
                            if (w_big || (w > {1'b0, b_sub})) begin
                                res_stv    = 1'b1;
                                res_st     = otcp_pkg::STATUS_BAD;
                                phase_next = otcp_pkg::PH_IDLE;
                            end else begin
                                budget_next = b_sub - w[PW-1:0];
                                fbl_next    = w[FW-1:0];
                                cand_next   = '1;
                                kpos_next   = 3'd0;
                                atag_next   = otcp_pkg::TAG_VENDOR;
                                cnt_next    = '0;
                                zero_next   = 1'b0;
                                if (w == '0) begin
                                    fields_next = fields_next - 1'b1;
                                    do_next     = 1'b1;
                                end else begin
                                    phase_next = otcp_pkg::PH_FBODY;
                                end
                            end
                        end
                    end
                    otcp_pkg::PH_FBODY: begin
                        if (atag_next != otcp_pkg::TAG_VENDOR) begin
                            emit_en  = 1'b1;
                            emit_tag = atag_next;
                        end else if (cand_next != '0) begin
                            for (int j = 0; j < NK; j++) begin
                                if (!hit && cand_reg[j]) begin
                                    if (({1'b0, kpos_next} < otcp_pkg::KEY_LEN[j]) &&
                                        (otcp_pkg::KEY_TEXT[j][kpos_next] == lc)) begin
                                        if ({1'b0, kpos_next} + 4'd1 ==
                                            otcp_pkg::KEY_LEN[j]) begin
                                            hit       = 1'b1;
                                            atag_next = 3'(j + 1);
                                        end
                                    end else begin
                                        cand_next[j] = 1'b0;
                                    end
                                end
                            end
                            if (hit) begin
                                cand_next = '0;
                            end
                            if (kpos_next != 3'd7) begin
                                kpos_next = kpos_next + 3'd1;
                            end
                        end
                        fbl_next = fbl_next - 1'b1;
                        if (fbl_next == '0) begin
                            fields_next = fields_next - 1'b1;
                            do_next     = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = otcp_pkg::PH_IDLE;
                    end
                endcase

                if (emit_en && !zero_next) begin
                    if (in_byte_reg == 8'd0) begin
                        zero_next = 1'b1;
                    end else if (cnt_next < max_len_reg) begin
                        res_val  = 1'b1;
                        res_tag  = emit_tag;
                        res_byte = in_byte_reg;
                        cnt_next = cnt_next + 1'b1;
                    end
                end

                if (do_next) begin
                    if (fields_next == '0) begin
                        res_stv    = 1'b1;
                        res_st     = otcp_pkg::STATUS_OK;
                        phase_next = otcp_pkg::PH_IDLE;
                    end else if (budget_next < otcp_pkg::LENGTH_WORD_BYTES) begin
                        res_stv    = 1'b1;
                        res_st     = otcp_pkg::STATUS_BAD;
                        phase_next = otcp_pkg::PH_IDLE;
                    end else begin
                        word_next  = '0;
                        wbi_next   = 2'd0;
                        phase_next = otcp_pkg::PH_FLEN;
                    end
                end

                if (in_last_reg && (phase_next != otcp_pkg::PH_IDLE)) begin
                    res_stv    = 1'b1;
                    res_st     = otcp_pkg::STATUS_BAD;
                    phase_next = otcp_pkg::PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg   <= otcp_pkg::MAX_VALUE_LENGTH_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= otcp_pkg::PH_IDLE;
            mpos_reg      <= 3'd0;
            wbi_reg       <= 2'd0;
            word_reg      <= '0;
            budget_reg    <= '0;
            fields_reg    <= '0;
            fbl_reg       <= '0;
            cand_reg      <= '1;
            kpos_reg      <= 3'd0;
            atag_reg      <= otcp_pkg::TAG_VENDOR;
            cnt_reg       <= '0;
            zero_reg      <= 1'b0;
        end else begin
            if (cfg_write && (paddr[2] == otcp_pkg::REG_MAX_VALUE_LENGTH)) begin
                max_len_reg <= pwdata[CW-1:0];
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (out_free) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                out_valid_reg <= res_val || res_stv;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            phase_reg  <= phase_next;
            mpos_reg   <= mpos_next;
            wbi_reg    <= wbi_next;
            word_reg   <= word_next;
            budget_reg <= budget_next;
            fields_reg <= fields_next;
            fbl_reg    <= fbl_next;
            cand_reg   <= cand_next;
            kpos_reg   <= kpos_next;
            atag_reg   <= atag_next;
            cnt_reg    <= cnt_next;
            zero_reg   <= zero_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_start_reg <= s_tuser;
            in_byte_reg  <= s_tdata[7:0];
            in_plen_reg  <= s_tdata[38:8];
            in_last_reg  <= s_tlast;
        end
        if (step) begin
            out_val_reg  <= res_val;
            out_tag_reg  <= res_tag;
            out_byte_reg <= res_byte;
            out_stv_reg  <= res_stv;
            out_st_reg   <= res_st;
        end
    end

    // A result that closes a packet always leaves the parser idle.
    a_status_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res_stv) |=> (phase_reg == otcp_pkg::PH_IDLE))
        else $error("status given but parser not idle");

    // Only results that carry a string byte or a status reach the output.
    a_result_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_val_reg || out_stv_reg))
        else $error("empty result in output register");

    // A field body is entered only with bytes left in it.
    a_body_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == otcp_pkg::PH_FBODY || phase_reg == otcp_pkg::PH_VENDOR)
        |-> (fbl_reg != '0))
        else $error("string phase with no bytes left");

    // The magic is checked only for packets long enough to hold a header.
    a_magic_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == otcp_pkg::PH_MAGIC) |-> (budget_reg >= otcp_pkg::MIN_PACKET_LENGTH))
        else $error("short packet reached magic check");

    // The input register is drained whenever the output side has room.
    a_input_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_free && !s_accept) |=> !in_valid_reg)
        else $error("input register not drained");

endmodule

// ===== tb/sv/otcp_parse_checker.sv =====
module otcp_parse_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          backlog
);
    import otcp_pkg::*;

    localparam logic [2:0] ADDR_MAX_LEN = {REG_MAX_VALUE_LENGTH, 2'b00};
    localparam int LEN_W = 32;
    localparam int HEADER_BYTES = 16;
    localparam int WORD_BYTES = 4;

    typedef struct packed {
        logic       value_valid;
        logic [2:0] tag;
        logic [7:0] value_byte;
        logic       status_valid;
        logic       status;
    } parse_result_t;

    parse_result_t parser_output_q[$];

    logic [15:0] max_len;
    phase_t      ph;
    logic [2:0]  magic_pos;
    logic [1:0]  wb_idx;
    logic [31:0] word_acc;
    logic [31:0] budget;
    logic [31:0] fields_left;
    logic [31:0] field_left;
    logic [4:0]  cand;
    logic [2:0]  key_pos;
    logic [2:0]  cur_tag;
    logic [15:0] emitted;
    logic        nul_seen;

    logic        r_val;
    logic [2:0]  r_tag;
    logic [7:0]  r_byte;
    logic        r_stv;
    logic        r_st;

    function automatic string key_text(input int j);
        case (j)
            0: return "title=";
            1: return "artist=";
            2: return "album=";
            3: return "date=";
            default: return "track=";
        endcase
    endfunction

    task automatic clear_packet_state();
        magic_pos = '0;
        wb_idx = '0;
        word_acc = '0;
        fields_left = '0;
        field_left = '0;
        cand = '1;
        key_pos = '0;
        cur_tag = TAG_VENDOR;
        emitted = '0;
        nul_seen = 1'b0;
    endtask

    task automatic close_packet(input logic code);
        r_stv = 1'b1;
        r_st = code;
        ph = PH_IDLE;
    endtask

    task automatic begin_word(input phase_t nxt);
        word_acc = '0;
        wb_idx = '0;
        ph = nxt;
    endtask

    task automatic take_word_byte(input logic [7:0] b, output logic done);
        word_acc = word_acc | ({24'd0, b} << (8 * wb_idx));
        wb_idx++;
        done = (wb_idx == 2'd0);
    endtask

    function automatic logic too_wide(input logic [31:0] w);
        return (w >> (LEN_W - 1)) != 0;
    endfunction

    task automatic emit_byte(input logic [7:0] b, input logic [2:0] t);
        if (!nul_seen) begin
            if (b == 8'h00) begin
                nul_seen = 1'b1;
            end else if (emitted < max_len) begin
                r_val = 1'b1;
                r_tag = t;
                r_byte = b;
                emitted++;
            end
        end
    endtask

    task automatic advance_field();
        if (fields_left == 0) begin
            close_packet(STATUS_OK);
        end else if (budget < WORD_BYTES) begin
            close_packet(STATUS_BAD);
        end else begin
            begin_word(PH_FLEN);
        end
    endtask

    task automatic match_key(input logic [7:0] b);
        logic [7:0] lc;
        string k;
        if (cur_tag != TAG_VENDOR) begin
            emit_byte(b, cur_tag);
        end else if (cand != 0) begin
            lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
            for (int j = 0; j < 5; j++) begin
                if (cand[j]) begin
                    k = key_text(j);
                    if (key_pos < k.len() && k[key_pos] == lc) begin
                        if (key_pos + 1 == k.len()) begin
                            cur_tag = 3'(j + 1);
                            cand = '0;
                            break;
                        end
                    end else begin
                        cand[j] = 1'b0;
                    end
                end
            end
            if (key_pos < 3'd7) key_pos++;
        end
    endtask

    task automatic parse_comment_byte(input logic st, input logic [7:0] b,
                                      input logic [30:0] plen, input logic lst);
        logic        done;
        logic        skip;
        logic [31:0] w;
        string       magic_word;
        magic_word = "OpusTags";
        r_val = 1'b0;
        r_tag = TAG_VENDOR;
        r_byte = 8'h00;
        r_stv = 1'b0;
        r_st = STATUS_OK;
        skip = 1'b0;
        if (st) begin
            clear_packet_state();
            ph = PH_MAGIC;
            budget = {1'b0, plen};
            if (plen < HEADER_BYTES) begin
                close_packet(STATUS_BAD);
                skip = 1'b1;
            end
        end
        if (!skip) begin
            case (ph)
                PH_MAGIC: begin
                    if (b != magic_word[magic_pos]) begin
                        close_packet(STATUS_BAD);
                    end else if (magic_pos == 3'd7) begin
                        magic_pos = '0;
                        begin_word(PH_VLEN);
                    end else begin
                        magic_pos++;
                    end
                end
                PH_VLEN: begin
                    take_word_byte(b, done);
                    if (done) begin
                        w = word_acc;
                        if (too_wide(w) || w > budget - HEADER_BYTES) begin
                            close_packet(STATUS_BAD);
                        end else begin
                            budget = budget - HEADER_BYTES - w;
                            field_left = w;
                            emitted = '0;
                            nul_seen = 1'b0;
                            if (w == 0) begin_word(PH_COUNT);
                            else ph = PH_VENDOR;
                        end
                    end
                end
                PH_VENDOR: begin
                    emit_byte(b, TAG_VENDOR);
                    field_left--;
                    if (field_left == 0) begin_word(PH_COUNT);
                end
                PH_COUNT: begin
                    take_word_byte(b, done);
                    if (done) begin
                        w = word_acc;
                        if (too_wide(w) || w > (budget >> 2)) begin
                            close_packet(STATUS_BAD);
                        end else begin
                            fields_left = w;
                            advance_field();
                        end
                    end
                end
                PH_FLEN: begin
                    take_word_byte(b, done);
                    if (done) begin
                        w = word_acc;
                        budget = budget - WORD_BYTES;
                        if (too_wide(w) || w > budget) begin
                            close_packet(STATUS_BAD);
                        end else begin
                            budget = budget - w;
                            field_left = w;
                            cand = '1;
                            key_pos = '0;
                            cur_tag = TAG_VENDOR;
                            emitted = '0;
                            nul_seen = 1'b0;
                            if (w == 0) begin
                                fields_left--;
                                advance_field();
                            end else begin
                                ph = PH_FBODY;
                            end
                        end
                    end
                end
                PH_FBODY: begin
                    match_key(b);
                    field_left--;
                    if (field_left == 0) begin
                        fields_left--;
                        advance_field();
                    end
                end
                default: ph = PH_IDLE;
            endcase
            if (lst && ph != PH_IDLE) close_packet(STATUS_BAD);
        end
        if (r_val || r_stv) parser_output_q.push_back('{r_val, r_tag, r_byte, r_stv, r_st});
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        parse_result_t want;
        if (!aresetn) begin
            parser_output_q.delete();
            fail_count = 0;
            max_len = MAX_VALUE_LENGTH_RESET;
            ph = PH_IDLE;
            budget = '0;
            clear_packet_state();
        end else begin
            if (m_tvalid && m_tready) begin
                if (parser_output_q.size() == 0) begin
                    $error("result with nothing outstanding: tdata %h tuser %b tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    want = parser_output_q.pop_front();
                    check_field("value_valid", 8'(want.value_valid), 8'(m_tuser));
                    check_field("tag", 8'(want.tag), 8'(m_tdata[2:0]));
                    check_field("value_byte", want.value_byte, m_tdata[10:3]);
                    check_field("status_valid", 8'(want.status_valid), 8'(m_tlast));
                    check_field("status", 8'(want.status), 8'(m_tdata[11]));
                end
            end
            if (s_tvalid && s_tready) begin
                parse_comment_byte(s_tuser, s_tdata[7:0], s_tdata[38:8], s_tlast);
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_MAX_LEN) begin
                max_len = pwdata[15:0];
            end
        end
        backlog <= parser_output_q.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import otcp_pkg::*;

    localparam logic [2:0] ADDR_MAX_LEN = {REG_MAX_VALUE_LENGTH, 2'b00};
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 16;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          backlog;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_go = 1'b0;
    int unsigned hold_left = 0;
    logic [7:0]  packet_bytes[$];

    always #4 aclk = ~aclk;

    opus_tags_comment_parser_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    otcp_parse_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .backlog(backlog)
    );

    always @(posedge aclk) begin
        if (hold_go) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin
        m_tready <= !hold_go && hold_left == 0 && ($urandom_range(99) >= stall_pct);
    end

    function automatic string tag_key(input int j);
        case (j)
            0: return "title=";
            1: return "artist=";
            2: return "album=";
            3: return "date=";
            default: return "track=";
        endcase
    endfunction

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) packet_bytes.push_back(w[8*i +: 8]);
    endtask

    task automatic push_text(input string s, input bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
                $urandom_range(1) == 1) c = c ^ 8'h20;
            packet_bytes.push_back(c);
        end
    endtask

    task automatic push_field(input string s);
        push_word(s.len());
        push_text(s, 1'b0);
    endtask

    task automatic push_string_byte();
        int r;
        r = $urandom_range(19);
        if (r == 0) packet_bytes.push_back(8'h00);
        else if (r == 1) packet_bytes.push_back(8'($urandom_range(255)));
        else packet_bytes.push_back(8'($urandom_range(32, 126)));
    endtask

    task automatic send_byte(input logic st, input logic [7:0] b, input logic [30:0] plen,
                             input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, plen, b};
        s_tuser <= st;
        s_tlast <= lst;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_packet(input logic [30:0] plen, input int n_send, input bit close);
        for (int i = 0; i < n_send; i++) begin
            send_byte(i == 0, packet_bytes[i], (i == 0) ? plen : 31'($urandom),
                      close && i == n_send - 1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (backlog != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_len(input logic [15:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_LEN;
        pwdata <= {16'h0000, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic build_random_packet(output logic [30:0] plen, output int n_send,
                                       output bit close);
        int    vlen;
        int    count;
        int    kind;
        int    vallen;
        int    cnt_at;
        int    flaw;
        string key;
        packet_bytes.delete();
        push_text("OpusTags", 1'b0);
        vlen = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(8);
        push_word(vlen);
        repeat (vlen) push_string_byte();
        count = $urandom_range(4);
        cnt_at = packet_bytes.size();
        push_word(count);
        repeat (count) begin
            kind = $urandom_range(7);
            vallen = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(8);
            if (kind < 5) begin
                key = tag_key(kind);
            end else if (kind == 5) begin
                key = tag_key($urandom_range(4));
                key = key.substr(0, $urandom_range(key.len() - 2));
                vallen = 0;
            end else if (kind == 6) begin
                key = "genre=";
            end else begin
                key = "";
            end
            push_word(key.len() + vallen);
            push_text(key, kind < 6);
            repeat (vallen) push_string_byte();
        end
        plen = 31'(packet_bytes.size() + $urandom_range(3));
        n_send = packet_bytes.size();
        close = 1'b1;
        flaw = $urandom_range(15);
        case (flaw)
            0: if (packet_bytes.size() > 16) plen = 31'($urandom_range(16, packet_bytes.size() - 1));
            1: plen = 31'($urandom_range(15));
            2: plen = 31'h7FFF_FFFF - 31'($urandom_range(255));
            3: packet_bytes[$urandom_range(packet_bytes.size() - 1)] = 8'($urandom_range(255));
            4: begin
                if ($urandom_range(1) == 0) packet_bytes[11] = packet_bytes[11] | 8'h80;
                else packet_bytes[cnt_at + 3] = packet_bytes[cnt_at + 3] | 8'h80;
            end
            5: n_send = $urandom_range(1, packet_bytes.size() - 1);
            6: begin
                n_send = $urandom_range(1, packet_bytes.size() - 1);
                close = 1'b0;
            end
            7: begin
                repeat ($urandom_range(1, 3)) packet_bytes.push_back(8'($urandom_range(255)));
                n_send = packet_bytes.size();
            end
            8: packet_bytes[cnt_at] = 8'($urandom_range(255));
            default: ;
        endcase
    endtask

    task automatic run_random_phase(input logic [15:0] limit, input int idle_pct,
                                    input int stall);
        logic [30:0] plen;
        int          n_send;
        bit          close;
        int          sent;
        drain();
        write_max_len(limit);
        send_idle_pct = idle_pct;
        stall_pct <= stall;
        sent = 0;
        while (sent < PHASE_BYTES) begin
            build_random_packet(plen, n_send, close);
            send_packet(plen, n_send, close);
            sent += n_send;
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_byte(1'b0, 8'hA5, 31'h7FFF_FFFF, 1'b1);
        send_byte(1'b1, "O", 31'd0, 1'b0);
        send_byte(1'b1, "O", 31'd15, 1'b1);

        packet_bytes.delete();
        push_text("OpusTags", 1'b0);
        push_word(0);
        push_word(0);
        send_packet(31'd16, 16, 1'b1);
        send_packet(31'h7FFF_FFFF, 16, 1'b1);
        packet_bytes[0] = "o";
        send_packet(31'd16, 16, 1'b1);

        packet_bytes.delete();
        push_text("OpusTags", 1'b0);
        push_word(4);
        packet_bytes.push_back(8'hFF);
        packet_bytes.push_back("v");
        packet_bytes.push_back(8'h00);
        packet_bytes.push_back(8'h01);
        push_word(9);
        push_field("TITLE=Song");
        push_field("artist=Ab");
        push_field("album=");
        push_field("Date=x9");
        push_field("tRaCk=7");
        push_field("titl");
        push_field("title");
        push_field("genre=pop");
        push_word(9);
        push_text("album=a", 1'b0);
        packet_bytes.push_back(8'h00);
        packet_bytes.push_back("b");
        send_packet(31'(packet_bytes.size()), packet_bytes.size(), 1'b1);
        send_byte(1'b0, 8'h00, 31'd0, 1'b0);
        send_byte(1'b0, 8'hFF, 31'h7FFF_FFFF, 1'b1);

        // Length and count words that break the budget or exceed the word range.
        packet_bytes.delete();
        push_text("OpusTags", 1'b0);
        push_word(32'h8000_0000);
        send_packet(31'h7FFF_FFFF, 12, 1'b1);
        packet_bytes.delete();
        push_text("OpusTags", 1'b0);
        push_word(5);
        push_text("vvvvv", 1'b0);
        push_word(0);
        send_packet(31'd20, 12, 1'b1);
        send_packet(31'd21, packet_bytes.size(), 1'b1);
        packet_bytes.delete();
        push_text("OpusTags", 1'b0);
        push_word(0);
        push_word(32'hFFFF_FFFF);
        send_packet(31'h7FFF_FFFF, 16, 1'b1);
        packet_bytes.delete();
        push_text("OpusTags", 1'b0);
        push_word(0);
        push_word(3);
        send_packet(31'd24, 16, 1'b1);
        packet_bytes.delete();
        push_text("OpusTags", 1'b0);
        push_word(0);
        push_word(2);
        push_word(0);
        push_word(0);
        send_packet(31'd24, packet_bytes.size(), 1'b1);
        packet_bytes.delete();
        push_text("OpusTags", 1'b0);
        push_word(0);
        push_word(2);
        push_field("abcd");
        send_packet(31'd27, packet_bytes.size(), 1'b1);
        packet_bytes.delete();
        push_text("OpusTags", 1'b0);
        push_word(0);
        push_word(1);
        push_word(1);
        packet_bytes.push_back("z");
        send_packet(31'd20, packet_bytes.size(), 1'b1);

        // Truncation, then a restart that abandons a packet in progress.
        packet_bytes.delete();
        push_text("OpusTags", 1'b0);
        push_word(3);
        push_text("abc", 1'b0);
        push_word(0);
        send_packet(31'd19, 14, 1'b1);
        send_packet(31'd19, 10, 1'b0);
        send_packet(31'd19, packet_bytes.size(), 1'b1);

        // The receiver holds off while a long vendor string keeps arriving.
        drain();
        packet_bytes.delete();
        push_text("OpusTags", 1'b0);
        push_word(260);
        repeat (260) packet_bytes.push_back(8'($urandom_range(32, 126)));
        push_word(0);
        hold_go <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        send_packet(31'(packet_bytes.size()), packet_bytes.size(), 1'b1);

        run_random_phase(16'd255, 0, 0);
        run_random_phase(16'd0, 84, 0);
        run_random_phase(16'hFFFF, 0, 84);
        run_random_phase(16'd3, 6, 6);
        run_random_phase(16'($urandom_range(1, 12)), 0, 0);
        drain();

        if (fail_count == 0) begin
            $display("opus_tags_comment_parser_top verification clean");
        end else begin
            $display("opus_tags_comment_parser_top verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #8000000;
        $display("opus_tags_comment_parser_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/otcp_pkg.sv
sv/opus_tags_comment_parser_top.sv
tb/sv/otcp_parse_checker.sv
tb/sv/tb_top.sv
